### rtl/cslm_pkg.sv
// shared types and constants of the channel scan link monitor
`default_nettype none
package cslm_pkg;

   // channel ring
   localparam int NUM_CHANNELS = 13;
   localparam int HOP_IDX_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CHAN_W       = 4;

   // field widths
   localparam int HOP_W   = 16;
   localparam int LOSS_W  = 20;
   localparam int CHECK_W = 16;
   localparam int SEQ_W   = 31;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // stream widths
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 2;

   // register reset values
   localparam logic [HOP_W-1:0]   HOP_INTERVAL_RST = HOP_W'(300);
   localparam logic [LOSS_W-1:0]  LOSS_TIMEOUT_RST = LOSS_W'(40000);
   localparam logic [CHECK_W-1:0] CHECK_PERIOD_RST = CHECK_W'(5000);
   localparam logic [LOSS_W-1:0]  SINCE_MAX        = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HOP_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOSS_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_PERIOD = 2'd2;

   // event kinds
   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_PACKET = 2'd1;
   localparam logic [1:0] ACT_RESET  = 2'd2;

   // sequence classes
   localparam logic [1:0] SEQ_NONE     = 2'd0;
   localparam logic [1:0] SEQ_IN_ORDER = 2'd1;
   localparam logic [1:0] SEQ_GAP      = 2'd2;
   localparam logic [1:0] SEQ_REPEAT   = 2'd3;

   // one result item
   typedef struct packed {
      logic             connected;
      logic             locked;
      logic [CHAN_W-1:0] channel;
      logic [1:0]       seq_status;
      logic [SEQ_W-1:0] missed_count;
   } result_type;

endpackage
`default_nettype wire

### rtl/channel_scan_link_monitor_core.sv
// link monitor top level: channel scan, lock, loss timeout and sequence checks
`default_nettype none
// Takes one event per transaction (a 1 ms tick, a packet arrival or a
// connection reset) and returns one result per event showing the link state
// after that event: connected, locked, current channel (index plus one) and
// the sequence class of the packet with its missed count. Every event is
// handled by the combinational update logic in front of the state registers,
// so one transaction is accepted every clock while the skid register is empty;
// the result is delivered from an output register, and a skid register keeps
// input ready while one result waits at the output. Configuration writes are
// taken every cycle and should only be issued while no events are in flight.
module channel_scan_link_monitor_core (
   input  wire logic clock,
   input  wire logic reset,
   // event channel
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [cslm_pkg::REQ_DATA_W-1:0]    req_tdata,  // seq_number[30:0], zero[31]
   input  wire logic [cslm_pkg::REQ_USER_W-1:0]    req_tuser,  // action[1:0], payload_ok[2], seq_present[3]
   // result channel
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [cslm_pkg::RSP_DATA_W-1:0]         rsp_tdata,  // connected[0], locked[1], channel[5:2], missed_count[36:6], zero[39:37]
   output logic [cslm_pkg::RSP_USER_W-1:0]         rsp_tuser,  // seq_status[1:0]
   // configuration write channel
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [cslm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [cslm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // configuration registers
   logic [cslm_pkg::HOP_W-1:0]   hop_interval_ff;
   logic [cslm_pkg::LOSS_W-1:0]  loss_timeout_ff;
   logic [cslm_pkg::CHECK_W-1:0] check_period_ff;

   // monitor state
   logic [cslm_pkg::HOP_IDX_W-1:0] hop_index_ff,   hop_index_in;
   logic [cslm_pkg::HOP_W-1:0]     hop_timer_ff,   hop_timer_in;
   logic [cslm_pkg::CHECK_W-1:0]   check_timer_ff, check_timer_in;
   logic [cslm_pkg::LOSS_W-1:0]    since_ff,       since_in;
   logic                           ever_ff,        ever_in;
   logic                           link_ff,        link_in;
   logic                           lock_ff,        lock_in;
   logic                           seq_seen_ff,    seq_seen_in;
   logic [cslm_pkg::SEQ_W-1:0]     last_seq_ff,    last_seq_in;

   // output register and skid
   cslm_pkg::result_type out_ff, out_in, skid_ff, skid_in, res;
   logic out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   // input fields
   logic [1:0]                 action;
   logic                       payload_ok;
   logic                       seq_present;
   logic [cslm_pkg::SEQ_W-1:0] seq_number;

   // tick helpers
   logic [cslm_pkg::LOSS_W-1:0]  since_tick;
   logic [cslm_pkg::HOP_W-1:0]   hop_inc;
   logic [cslm_pkg::CHECK_W-1:0] check_inc;
   logic [cslm_pkg::HOP_IDX_W-1:0] hop_next_idx;

   // sequence helpers
   logic [cslm_pkg::SEQ_W:0]   seq_expected;
   logic [cslm_pkg::SEQ_W:0]   seq_ext;
   logic [cslm_pkg::SEQ_W:0]   seq_diff;
   logic [1:0]                 status;
   logic [cslm_pkg::SEQ_W-1:0] missed;

   logic accept, take;

   assign action      = req_tuser[1:0];
   assign payload_ok  = req_tuser[2];
   assign seq_present = req_tuser[3];
   assign seq_number  = req_tdata[cslm_pkg::SEQ_W-1:0];

   assign req_tready = ~skid_valid_ff;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid & req_tready;
   assign take       = out_valid_ff & rsp_tready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         hop_interval_ff <= cslm_pkg::HOP_INTERVAL_RST;
         loss_timeout_ff <= cslm_pkg::LOSS_TIMEOUT_RST;
         check_period_ff <= cslm_pkg::CHECK_PERIOD_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            cslm_pkg::CSR_HOP_INTERVAL: hop_interval_ff <= csr_wdata[cslm_pkg::HOP_W-1:0];
            cslm_pkg::CSR_LOSS_TIMEOUT: loss_timeout_ff <= csr_wdata[cslm_pkg::LOSS_W-1:0];
            cslm_pkg::CSR_CHECK_PERIOD: check_period_ff <= csr_wdata[cslm_pkg::CHECK_W-1:0];
            default: ;
         endcase
      end
   end

   // tick arithmetic
   always_comb begin
      since_tick = (since_ff != cslm_pkg::SINCE_MAX) ? since_ff + 1'b1 : since_ff;
      hop_inc    = hop_timer_ff + 1'b1;
      check_inc  = check_timer_ff + 1'b1;
      if (hop_index_ff == cslm_pkg::HOP_IDX_W'(cslm_pkg::NUM_CHANNELS - 1)) begin
         hop_next_idx = '0;
      end else begin
         hop_next_idx = hop_index_ff + 1'b1;
      end
   end

   // sequence classification
   always_comb begin
      seq_expected = {1'b0, last_seq_ff} + 1'b1;
      seq_ext      = {1'b0, seq_number};
      seq_diff     = seq_ext - seq_expected;
      if (!seq_seen_ff) begin
         status = cslm_pkg::SEQ_NONE;
         missed = '0;
      end else if (seq_ext == seq_expected) begin
         status = cslm_pkg::SEQ_IN_ORDER;
         missed = '0;
      end else if (seq_ext > seq_expected) begin
         status = cslm_pkg::SEQ_GAP;
         missed = seq_diff[cslm_pkg::SEQ_W-1:0];
      end else begin
         status = cslm_pkg::SEQ_REPEAT;
         missed = '0;
      end
   end

   // event update
   always_comb begin
      hop_index_in   = hop_index_ff;
      hop_timer_in   = hop_timer_ff;
      check_timer_in = check_timer_ff;
      since_in       = since_ff;
      ever_in        = ever_ff;
      link_in        = link_ff;
      lock_in        = lock_ff;
      seq_seen_in    = seq_seen_ff;
      last_seq_in    = last_seq_ff;
      res.seq_status   = cslm_pkg::SEQ_NONE;
      res.missed_count = '0;

      unique case (action)
         cslm_pkg::ACT_TICK: begin
            since_in = since_tick;
            // hop timer and channel scan
            if (hop_inc >= hop_interval_ff) begin
               hop_timer_in = '0;
               if (!lock_ff) begin
                  hop_index_in = hop_next_idx;
               end
            end else begin
               hop_timer_in = hop_inc;
            end
            // periodic loss check
            if (check_inc >= check_period_ff) begin
               check_timer_in = '0;
               if (ever_ff && link_ff && (since_tick > loss_timeout_ff)) begin
                  link_in = 1'b0;
                  lock_in = 1'b0;
               end
            end else begin
               check_timer_in = check_inc;
            end
         end
         cslm_pkg::ACT_PACKET: begin
            if (payload_ok) begin
               if (seq_present) begin
                  res.seq_status   = status;
                  res.missed_count = missed;
                  last_seq_in      = seq_number;
                  seq_seen_in      = 1'b1;
               end
               since_in = '0;
               ever_in  = 1'b1;
               if (!link_ff) begin
                  link_in = 1'b1;
                  lock_in = 1'b1;
               end
            end
         end
         cslm_pkg::ACT_RESET: begin
            since_in = '0;
            ever_in  = 1'b0;
            link_in  = 1'b0;
         end
         default: ;
      endcase

      res.connected = link_in;
      res.locked    = lock_in;
      res.channel   = cslm_pkg::CHAN_W'({{(cslm_pkg::CHAN_W + 1){1'b0}}, hop_index_in} + 1'b1);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hop_index_ff   <= '0;
         hop_timer_ff   <= '0;
         check_timer_ff <= '0;
         since_ff       <= '0;
         ever_ff        <= 1'b0;
         link_ff        <= 1'b0;
         lock_ff        <= 1'b0;
         seq_seen_ff    <= 1'b0;
         last_seq_ff    <= '0;
      end else if (accept) begin
         hop_index_ff   <= hop_index_in;
         hop_timer_ff   <= hop_timer_in;
         check_timer_ff <= check_timer_in;
         since_ff       <= since_in;
         ever_ff        <= ever_in;
         link_ff        <= link_in;
         lock_ff        <= lock_in;
         seq_seen_ff    <= seq_seen_in;
         last_seq_ff    <= last_seq_in;
      end
   end

   // output register and skid control
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.seq_status;
   assign rsp_tdata  = {3'b000, out_ff.missed_count, out_ff.channel,
                        out_ff.locked, out_ff.connected};

endmodule
`default_nettype wire

### verif/channel_scan_link_monitor_core_tb.sv
// self-checking testbench of the channel scan link monitor core
`default_nettype none
module channel_scan_link_monitor_core_tb;
   import cslm_pkg::*;

   localparam logic [1:0] ACT_UNUSED  = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         SETTLE      = 6;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   channel_scan_link_monitor_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // shadow copy of the registers and link state
   logic [HOP_W-1:0]   cfg_hop_interval;
   logic [LOSS_W-1:0]  cfg_loss_timeout;
   logic [CHECK_W-1:0] cfg_check_period;
   int unsigned        hop_pos;
   logic [HOP_W-1:0]   dwell_count;
   logic [CHECK_W-1:0] check_count;
   logic [LOSS_W-1:0]  quiet_ticks;
   logic               heard_any;
   logic               link_alive;
   logic               chan_held;
   logic               seq_known;
   logic [SEQ_W-1:0]   prev_seq;

   result_type link_reports_due[$];
   int         mismatches  = 0;
   int         cycle_count = 0;
   int         idle_pct    = 0;
   int         stall_pct   = 0;

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic note_error(input string msg);
      if (mismatches < 10)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   // expected link state after one event, updates the shadow state
   function automatic result_type advance_link_state(input logic [1:0] act, input logic pok,
                                                     input logic spres, input logic [SEQ_W-1:0] seq);
      result_type  r;
      logic [31:0] next_seq;
      logic [31:0] wide_seq;
      r = '0;
      case (act)
         ACT_TICK: begin
            if (quiet_ticks != SINCE_MAX)
               quiet_ticks = quiet_ticks + 1'b1;
            dwell_count = dwell_count + 1'b1;
            if (dwell_count >= cfg_hop_interval) begin
               dwell_count = '0;
               if (!chan_held)
                  hop_pos = (hop_pos + 1) % NUM_CHANNELS;
            end
            check_count = check_count + 1'b1;
            if (check_count >= cfg_check_period) begin
               check_count = '0;
               if (heard_any && link_alive && quiet_ticks > cfg_loss_timeout) begin
                  link_alive = 1'b0;
                  chan_held  = 1'b0;
               end
            end
         end
         ACT_PACKET: begin
            if (pok) begin
               if (spres) begin
                  if (seq_known) begin
                     next_seq = {1'b0, prev_seq} + 32'd1;
                     wide_seq = {1'b0, seq};
                     if (wide_seq == next_seq) begin
                        r.seq_status = SEQ_IN_ORDER;
                     end else if (wide_seq > next_seq) begin
                        r.seq_status   = SEQ_GAP;
                        r.missed_count = SEQ_W'(wide_seq - next_seq);
                     end else begin
                        r.seq_status = SEQ_REPEAT;
                     end
                  end
                  prev_seq  = seq;
                  seq_known = 1'b1;
               end
               quiet_ticks = '0;
               heard_any   = 1'b1;
               if (!link_alive) begin
                  link_alive = 1'b1;
                  chan_held  = 1'b1;
               end
            end
         end
         ACT_RESET: begin
            quiet_ticks = '0;
            heard_any   = 1'b0;
            link_alive  = 1'b0;
         end
         default: ;
      endcase
      r.connected = link_alive;
      r.locked    = chan_held;
      r.channel   = CHAN_W'(hop_pos + 1);
      return r;
   endfunction

   // one event transaction; valid stays high for a following event
   task automatic send_event(input logic [1:0] act, input logic pok, input logic spres,
                             input logic [SEQ_W-1:0] seq);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, seq};
      req_tuser  <= {spres, pok, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      link_reports_due.push_back(advance_link_state(act, pok, spres, seq));
   endtask

   // stop sending and wait until every result is back
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (link_reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // write all three registers back to back
   task automatic configure(input logic [HOP_W-1:0] hop, input logic [LOSS_W-1:0] loss,
                            input logic [CHECK_W-1:0] chk);
      logic [CSR_IDX_W-1:0]  idx[3];
      logic [CSR_DATA_W-1:0] val[3];
      idx = '{CSR_HOP_INTERVAL, CSR_LOSS_TIMEOUT, CSR_CHECK_PERIOD};
      val = '{CSR_DATA_W'(hop), loss, CSR_DATA_W'(chk)};
      settle_idle();
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (idx[i])
            CSR_HOP_INTERVAL: cfg_hop_interval = val[i][HOP_W-1:0];
            CSR_LOSS_TIMEOUT: cfg_loss_timeout = val[i][LOSS_W-1:0];
            CSR_CHECK_PERIOD: cfg_check_period = val[i][CHECK_W-1:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // random mix: mostly ticks and well-formed sequence streams, some noise
   task automatic run_traffic(input int count);
      int               sent;
      int               pick;
      int               span;
      logic [SEQ_W-1:0] rnd;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         rnd  = SEQ_W'($urandom());
         if (pick < 5) begin
            // quiet stretch long enough to hit the loss check
            span = $urandom_range(40, 8);
            repeat (span) send_event(ACT_TICK, 1'($urandom()), 1'($urandom()), SEQ_W'($urandom()));
            sent += span;
         end else begin
            if (pick < 50)
               send_event(ACT_TICK, 1'($urandom()), 1'($urandom()), rnd);
            else if (pick < 75)
               send_event(ACT_PACKET, 1'b1, 1'b1, prev_seq + 1'b1);
            else if (pick < 79)
               send_event(ACT_PACKET, 1'b1, 1'b1, prev_seq + SEQ_W'($urandom_range(60, 2)));
            else if (pick < 82)
               send_event(ACT_PACKET, 1'b1, 1'b1, rnd);
            else if (pick < 86)
               send_event(ACT_PACKET, 1'b1, 1'b1, prev_seq - SEQ_W'($urandom_range(20, 0)));
            else if (pick < 89)
               send_event(ACT_PACKET, 1'b1, 1'b0, rnd);
            else if (pick < 93)
               send_event(ACT_PACKET, 1'b0, 1'($urandom()), rnd);
            else if (pick < 97)
               send_event(ACT_RESET, 1'($urandom()), 1'($urandom()), rnd);
            else
               send_event(ACT_UNUSED, 1'($urandom()), 1'($urandom()), rnd);
            sent++;
         end
      end
   endtask

   // result checker
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got.connected    = rsp_tdata[0];
         got.locked       = rsp_tdata[1];
         got.channel      = rsp_tdata[5:2];
         got.missed_count = rsp_tdata[36:6];
         got.seq_status   = rsp_tuser[1:0];
         if (link_reports_due.size() == 0) begin
            note_error($sformatf("unexpected result %p", got));
         end else begin
            want = link_reports_due.pop_front();
            if (got.connected !== want.connected || got.locked !== want.locked ||
                got.channel !== want.channel || got.seq_status !== want.seq_status ||
                got.missed_count !== want.missed_count)
               note_error($sformatf("expected %p, got %p", want, got));
         end
      end
   end

   // event kinds, sequence classes and reset-value registers
   task automatic test_directed();
      idle_pct  = 0;
      stall_pct = 0;
      send_event(ACT_TICK, 1'b0, 1'b0, '0);
      send_event(ACT_UNUSED, 1'b1, 1'b1, '1);
      send_event(ACT_PACKET, 1'b0, 1'b1, SEQ_W'(5));
      send_event(ACT_RESET, 1'b0, 1'b0, '0);
      send_event(ACT_PACKET, 1'b1, 1'b0, '1);
      send_event(ACT_PACKET, 1'b1, 1'b1, '0);
      send_event(ACT_PACKET, 1'b1, 1'b1, SEQ_W'(1));
      send_event(ACT_PACKET, 1'b1, 1'b1, SEQ_W'(1));
      send_event(ACT_PACKET, 1'b1, 1'b1, '0);
      send_event(ACT_PACKET, 1'b1, 1'b1, '1);
      send_event(ACT_PACKET, 1'b1, 1'b1, '1);
      // wrap of the sequence number reads as a decrease
      send_event(ACT_PACKET, 1'b1, 1'b1, '0);
      send_event(ACT_PACKET, 1'b1, 1'b1, SEQ_W'(2));
      send_event(ACT_RESET, 1'b1, 1'b1, '1);
      send_event(ACT_TICK, 1'b1, 1'b1, '1);
      // sequence tracking survives the connection reset
      send_event(ACT_PACKET, 1'b1, 1'b1, SEQ_W'(3));
      send_event(ACT_PACKET, 1'b0, 1'b1, SEQ_W'(9));
      send_event(ACT_PACKET, 1'b1, 1'b1, SEQ_W'(4));
      send_event(ACT_PACKET, 1'b1, 1'b1, SEQ_W'(32'h4000_0000));
      repeat (3) send_event(ACT_TICK, 1'b0, 1'b1, '0);
   endtask

   // zero periods behave as one, zero timeout drops on any quiet tick
   task automatic test_zero_periods();
      configure('0, '0, '0);
      idle_pct  = 0;
      stall_pct = 0;
      run_traffic(150);
   endtask

   task automatic test_unit_periods();
      configure(HOP_W'(1), LOSS_W'(1), CHECK_W'(1));
      idle_pct  = 58;
      stall_pct = 0;
      run_traffic(150);
   endtask

   task automatic test_loss_drop();
      configure(HOP_W'(3), LOSS_W'(12), CHECK_W'(5));
      idle_pct  = 0;
      stall_pct = 58;
      run_traffic(250);
   endtask

   // maximum timeout: the link is never dropped
   task automatic test_loss_never();
      configure(HOP_W'(2), '1, CHECK_W'(1));
      idle_pct  = 10;
      stall_pct = 10;
      run_traffic(150);
   endtask

   task automatic test_max_periods();
      configure('1, '1, '1);
      idle_pct  = 10;
      stall_pct = 10;
      run_traffic(100);
   endtask

   task automatic test_reset_values();
      configure(HOP_INTERVAL_RST, LOSS_TIMEOUT_RST, CHECK_PERIOD_RST);
      idle_pct  = 0;
      stall_pct = 0;
      run_traffic(100);
   endtask

   // main sequence
   initial begin
      cfg_hop_interval = HOP_INTERVAL_RST;
      cfg_loss_timeout = LOSS_TIMEOUT_RST;
      cfg_check_period = CHECK_PERIOD_RST;
      hop_pos     = 0;
      dwell_count = '0;
      check_count = '0;
      quiet_ticks = '0;
      heard_any   = 1'b0;
      link_alive  = 1'b0;
      chan_held   = 1'b0;
      seq_known   = 1'b0;
      prev_seq    = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_zero_periods();
      test_unit_periods();
      test_loss_drop();
      test_loss_never();
      test_max_periods();
      test_reset_values();
      settle_idle();
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire

### channel_scan_link_monitor_core.f
rtl/cslm_pkg.sv
rtl/channel_scan_link_monitor_core.sv
verif/channel_scan_link_monitor_core_tb.sv
